/* hw/rtl/tcp_pkg.sv */
`timescale 1ns / 1ps

package tcp_pkg;

	typedef logic [2:0] cmd_t;

	localparam cmd_t CMD_TICK  = 3'd0;
	localparam cmd_t CMD_READ  = 3'd1;
	localparam cmd_t CMD_WRITE = 3'd2;
	localparam cmd_t CMD_ACK0  = 3'd3;
	localparam cmd_t CMD_ACK1  = 3'd4;

	localparam logic [7:0] ADDR_TCON = 8'h88;
	localparam logic [7:0] ADDR_TMOD = 8'h89;
	localparam logic [7:0] ADDR_TL0  = 8'h8a;
	localparam logic [7:0] ADDR_TL1  = 8'h8b;
	localparam logic [7:0] ADDR_TH0  = 8'h8c;
	localparam logic [7:0] ADDR_TH1  = 8'h8d;

	// bit positions in TCON and TMOD
	localparam int TF1_BIT   = 7;
	localparam int TR1_BIT   = 6;
	localparam int TF0_BIT   = 5;
	localparam int TR0_BIT   = 4;
	localparam int GATE1_BIT = 7;
	localparam int GATE0_BIT = 3;

	localparam logic [7:0] COUNT_MAX = 8'hff;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_13BIT  = 2'd0;
	localparam mode_t MODE_16BIT  = 2'd1;
	localparam mode_t MODE_RELOAD = 2'd2;
	localparam mode_t MODE_SPLIT  = 2'd3;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] sfr_addr;
		logic [7:0] write_data;
		logic       int0_level;
		logic       int1_level;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq0;
		logic       irq1;
	} result_t;

endpackage

/* hw/rtl/tcp_item_if.sv */
`timescale 1ns / 1ps

interface tcp_item_if;
	logic          valid;
	logic          ready;
	tcp_pkg::item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/tcp_result_if.sv */
`timescale 1ns / 1ps

interface tcp_result_if;
	logic            valid;
	logic            ready;
	tcp_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/tcp_count.sv */
`timescale 1ns / 1ps

// one count of a timer in mode 0, 1 or 2; mode 3 holds
module tcp_count (
	input  logic           en,
	input  tcp_pkg::mode_t mode,
	input  logic [7:0]     lo,
	input  logic [7:0]     hi,
	output logic [7:0]     lo_next,
	output logic [7:0]     hi_next,
	output logic           ovf
);

	logic [5:0] presc;

	assign presc = {1'b0, lo[4:0]} + 6'd1;

	always_comb begin
		lo_next = lo;
		hi_next = hi;
		ovf     = 1'b0;
		if (en) begin
			case (mode)
				tcp_pkg::MODE_13BIT: begin
					// upper TL bits are cleared on every count
					lo_next = {3'b000, presc[4:0]};
					if (presc[5]) begin
						hi_next = hi + 8'd1;
						ovf     = (hi == tcp_pkg::COUNT_MAX);
					end
				end
				tcp_pkg::MODE_16BIT: begin
					lo_next = lo + 8'd1;
					if (lo == tcp_pkg::COUNT_MAX) begin
						hi_next = hi + 8'd1;
						ovf     = (hi == tcp_pkg::COUNT_MAX);
					end
				end
				tcp_pkg::MODE_RELOAD: begin
					if (lo == tcp_pkg::COUNT_MAX) begin
						lo_next = hi;
						ovf     = 1'b1;
					end else begin
						lo_next = lo + 8'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* hw/rtl/timer_counter_pair_8051_unit.sv */
`timescale 1ns / 1ps

// timer 0 / timer 1 pair of an 8051 behind TCON, TMOD, TL0, TL1, TH0, TH1
//
// item channel (sink): each transfer carries one command: count tick, SFR
// read, SFR write, or acknowledge of the timer 0 or timer 1 interrupt,
// together with the INT0 and INT1 pin levels used for gating
// result channel (source): exactly one transfer per item, in order, with the
// read byte (zero unless the command is a read) and TF0/TF1 after the item
//
// an item lands in the input register at its transfer, and its result is then
// registered in the result register, from which it is offered. throughput: one
// item per cycle while result ready stays high, set by the single pass
// through the timer update logic between the input and result registers
//
// reset clears all six SFRs and both pipeline valids. when the receiver
// stalls, the result register holds and one more item waits in the input
// register; item ready drops only while both are full and result ready is low
module timer_counter_pair_8051_unit (
	input logic          clk,
	input logic          arst_n,
	tcp_item_if.sink     item,
	tcp_result_if.source result
);

	logic             valid_s1;
	tcp_pkg::item_t   item_s1;
	logic             result_valid_q;
	tcp_pkg::result_t result_q;

	logic [7:0] tcon_q, tmod_q, tl0_q, th0_q, tl1_q, th1_q;
	logic [7:0] tcon_d, tmod_d, tl0_d, th0_d, tl1_d, th1_d;
	logic [7:0] read_d;

	logic advance;

	tcp_pkg::mode_t m0, m1;
	logic run0, run1;
	logic [7:0] c0_lo, c0_hi, c1_lo, c1_hi;
	logic c0_ovf, c1_ovf;

	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || !result_valid_q || result.ready;

	assign m0   = tmod_q[1:0];
	assign m1   = tmod_q[5:4];
	assign run0 = tcon_q[tcp_pkg::TR0_BIT] &&
		(!tmod_q[tcp_pkg::GATE0_BIT] || item_s1.int0_level);
	assign run1 = tcon_q[tcp_pkg::TR1_BIT] &&
		(!tmod_q[tcp_pkg::GATE1_BIT] || item_s1.int1_level);

	tcp_count u_count0 (
		.en      (run0 && m0 != tcp_pkg::MODE_SPLIT),
		.mode    (m0),
		.lo      (tl0_q),
		.hi      (th0_q),
		.lo_next (c0_lo),
		.hi_next (c0_hi),
		.ovf     (c0_ovf)
	);

	tcp_count u_count1 (
		.en      (run1),
		.mode    (m1),
		.lo      (tl1_q),
		.hi      (th1_q),
		.lo_next (c1_lo),
		.hi_next (c1_hi),
		.ovf     (c1_ovf)
	);

	always_comb begin
		tcon_d = tcon_q;
		tmod_d = tmod_q;
		tl0_d  = tl0_q;
		th0_d  = th0_q;
		tl1_d  = tl1_q;
		th1_d  = th1_q;
		read_d = 8'h00;
		case (item_s1.cmd)
			tcp_pkg::CMD_TICK: begin
				if (m0 == tcp_pkg::MODE_SPLIT) begin
					// split timer 0: TL0 under run0, TH0 under TR1 alone
					if (run0) begin
						tl0_d = tl0_q + 8'd1;
						if (tl0_q == tcp_pkg::COUNT_MAX)
							tcon_d[tcp_pkg::TF0_BIT] = 1'b1;
					end
					if (tcon_q[tcp_pkg::TR1_BIT]) begin
						th0_d = th0_q + 8'd1;
						if (th0_q == tcp_pkg::COUNT_MAX)
							tcon_d[tcp_pkg::TF1_BIT] = 1'b1;
					end
				end else begin
					tl0_d = c0_lo;
					th0_d = c0_hi;
					if (c0_ovf)
						tcon_d[tcp_pkg::TF0_BIT] = 1'b1;
				end
				tl1_d = c1_lo;
				th1_d = c1_hi;
				if (c1_ovf)
					tcon_d[tcp_pkg::TF1_BIT] = 1'b1;
			end
			tcp_pkg::CMD_READ: begin
				unique case (item_s1.sfr_addr)
					tcp_pkg::ADDR_TCON: read_d = tcon_q;
					tcp_pkg::ADDR_TMOD: read_d = tmod_q;
					tcp_pkg::ADDR_TL0:  read_d = tl0_q;
					tcp_pkg::ADDR_TL1:  read_d = tl1_q;
					tcp_pkg::ADDR_TH0:  read_d = th0_q;
					tcp_pkg::ADDR_TH1:  read_d = th1_q;
					default:            read_d = 8'h00;
				endcase
			end
			tcp_pkg::CMD_WRITE: begin
				unique case (item_s1.sfr_addr)
					tcp_pkg::ADDR_TCON: tcon_d = item_s1.write_data;
					tcp_pkg::ADDR_TMOD: tmod_d = item_s1.write_data;
					tcp_pkg::ADDR_TL0:  tl0_d  = item_s1.write_data;
					tcp_pkg::ADDR_TL1:  tl1_d  = item_s1.write_data;
					tcp_pkg::ADDR_TH0:  th0_d  = item_s1.write_data;
					tcp_pkg::ADDR_TH1:  th1_d  = item_s1.write_data;
					default: begin
					end
				endcase
			end
			tcp_pkg::CMD_ACK0: tcon_d[tcp_pkg::TF0_BIT] = 1'b0;
			tcp_pkg::CMD_ACK1: tcon_d[tcp_pkg::TF1_BIT] = 1'b0;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance)
				result_valid_q <= 1'b1;
			else if (result.ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			item_s1 <= item.data;
		if (advance) begin
			result_q.read_data <= read_d;
			result_q.irq0      <= tcon_d[tcp_pkg::TF0_BIT];
			result_q.irq1      <= tcon_d[tcp_pkg::TF1_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcon_q <= 8'h00;
			tmod_q <= 8'h00;
			tl0_q  <= 8'h00;
			th0_q  <= 8'h00;
			tl1_q  <= 8'h00;
			th1_q  <= 8'h00;
		end else if (advance) begin
			tcon_q <= tcon_d;
			tmod_q <= tmod_d;
			tl0_q  <= tl0_d;
			th0_q  <= th0_d;
			tl1_q  <= tl1_d;
			th1_q  <= th1_d;
		end
	end

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

endmodule

/* hw/rtl/tcp_checker.sv */
`timescale 1ns / 1ps

module tcp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input tcp_pkg::item_t   item_data,
	input logic             result_valid,
	input logic             result_ready,
	input tcp_pkg::result_t result_data
);

	logic [1:0] pending_q;
	logic item_xfer, result_xfer;

	assign item_xfer   = item_valid && item_ready;
	assign result_xfer = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= 2'd0;
		else
			pending_q <= pending_q + {1'b0, item_xfer} - {1'b0, result_xfer};
	end

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// at most one item in the input register and one in the result register
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3 && (pending_q != 2'd0 || !result_valid))
		else $error("items in flight out of range");

	// an item into an empty block passes the input register and is offered from the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && pending_q == 2'd0 |-> ##2 result_valid)
		else $error("result missing after item");

	// timer 0 acknowledge into an empty block clears TF0 in its own result
	a_ack0: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && pending_q == 2'd0 && item_data.cmd == tcp_pkg::CMD_ACK0
		|-> ##2 !result_data.irq0 && result_data.read_data == 8'h00)
		else $error("timer 0 acknowledge did not clear flag");

endmodule

bind timer_counter_pair_8051_unit tcp_checker u_tcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_data    (item.data),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam tcp_pkg::cmd_t CMD_SPARE_FIRST = 3'd5;
	localparam tcp_pkg::cmd_t CMD_SPARE_LAST  = 3'd7;
	localparam logic [7:0] ADDR_LOWEST     = 8'h00;
	localparam logic [7:0] ADDR_HIGHEST    = 8'hff;
	localparam int         RANDOM_ITEMS    = 930;
	localparam int         QUIET_AT        = 600;
	localparam int         STEADY_FROM     = 700;
	localparam int         STEADY_TO       = 800;
	localparam int         LONG_HOLD_AT    = 300;
	localparam int         LONG_HOLD_LEN   = 120;
	localparam int         DRAIN_CYCLES    = 8;

	// one directed transfer, with its reply typed in where it is obvious
	typedef struct {
		tcp_pkg::item_t   it;
		bit               typed;
		tcp_pkg::result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	tcp_item_if   item_ch();
	tcp_result_if result_ch();

	timer_counter_pair_8051_unit DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow SFRs
	logic [7:0] tcon = '0;
	logic [7:0] tmod = '0;
	logic [7:0] tl0  = '0;
	logic [7:0] th0  = '0;
	logic [7:0] tl1  = '0;
	logic [7:0] th1  = '0;

	row_t             preset_q[$];
	tcp_pkg::result_t reply_q[$];
	row_t             dir_rows[$];
	int      mismatches = 0;
	int      replies_seen = 0;
	bit      steady = 1'b0;
	bit      long_hold_done = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// one count of a timer in mode 0, 1 or 2, returns {overflow, th, tl}
	function automatic logic [16:0] timer_advance(tcp_pkg::mode_t m, logic [7:0] lo,
			logic [7:0] hi);
		logic       ovf;
		logic [5:0] pre;
		ovf = 1'b0;
		pre = {1'b0, lo[4:0]} + 6'd1;
		case (m)
		tcp_pkg::MODE_13BIT: begin
			lo = {3'b000, pre[4:0]};
			if (pre[5]) begin
				ovf = (hi == tcp_pkg::COUNT_MAX);
				hi = hi + 8'd1;
			end
		end
		tcp_pkg::MODE_16BIT: begin
			if (lo == tcp_pkg::COUNT_MAX) begin
				ovf = (hi == tcp_pkg::COUNT_MAX);
				hi = hi + 8'd1;
			end
			lo = lo + 8'd1;
		end
		tcp_pkg::MODE_RELOAD: begin
			if (lo == tcp_pkg::COUNT_MAX) begin
				ovf = 1'b1;
				lo = hi;
			end else begin
				lo = lo + 8'd1;
			end
		end
		default: ;
		endcase
		return {ovf, hi, lo};
	endfunction

	function automatic tcp_pkg::result_t timer_pair_step(tcp_pkg::item_t it);
		tcp_pkg::result_t r;
		tcp_pkg::mode_t   m0, m1;
		logic        run0, run1;
		logic [16:0] nxt;
		r = '0;
		case (it.cmd)
		tcp_pkg::CMD_TICK: begin
			m0 = tmod[1:0];
			m1 = tmod[5:4];
			run0 = tcon[tcp_pkg::TR0_BIT] && (!tmod[tcp_pkg::GATE0_BIT] || it.int0_level);
			run1 = tcon[tcp_pkg::TR1_BIT] && (!tmod[tcp_pkg::GATE1_BIT] || it.int1_level);
			if (m0 == tcp_pkg::MODE_SPLIT) begin
				if (run0) begin
					if (tl0 == tcp_pkg::COUNT_MAX)
						tcon[tcp_pkg::TF0_BIT] = 1'b1;
					tl0 = tl0 + 8'd1;
				end
				// TH0 runs on TR1 alone and borrows TF1
				if (tcon[tcp_pkg::TR1_BIT]) begin
					if (th0 == tcp_pkg::COUNT_MAX)
						tcon[tcp_pkg::TF1_BIT] = 1'b1;
					th0 = th0 + 8'd1;
				end
			end else if (run0) begin
				nxt = timer_advance(m0, tl0, th0);
				{th0, tl0} = nxt[15:0];
				if (nxt[16])
					tcon[tcp_pkg::TF0_BIT] = 1'b1;
			end
			if (m1 != tcp_pkg::MODE_SPLIT && run1) begin
				nxt = timer_advance(m1, tl1, th1);
				{th1, tl1} = nxt[15:0];
				if (nxt[16])
					tcon[tcp_pkg::TF1_BIT] = 1'b1;
			end
		end
		tcp_pkg::CMD_READ: begin
			case (it.sfr_addr)
			tcp_pkg::ADDR_TCON: r.read_data = tcon;
			tcp_pkg::ADDR_TMOD: r.read_data = tmod;
			tcp_pkg::ADDR_TL0:  r.read_data = tl0;
			tcp_pkg::ADDR_TL1:  r.read_data = tl1;
			tcp_pkg::ADDR_TH0:  r.read_data = th0;
			tcp_pkg::ADDR_TH1:  r.read_data = th1;
			default:   r.read_data = '0;
			endcase
		end
		tcp_pkg::CMD_WRITE: begin
			case (it.sfr_addr)
			tcp_pkg::ADDR_TCON: tcon = it.write_data;
			tcp_pkg::ADDR_TMOD: tmod = it.write_data;
			tcp_pkg::ADDR_TL0:  tl0 = it.write_data;
			tcp_pkg::ADDR_TL1:  tl1 = it.write_data;
			tcp_pkg::ADDR_TH0:  th0 = it.write_data;
			tcp_pkg::ADDR_TH1:  th1 = it.write_data;
			default: ;
			endcase
		end
		tcp_pkg::CMD_ACK0: tcon[tcp_pkg::TF0_BIT] = 1'b0;
		tcp_pkg::CMD_ACK1: tcon[tcp_pkg::TF1_BIT] = 1'b0;
		default: ;
		endcase
		r.irq0 = tcon[tcp_pkg::TF0_BIT];
		r.irq1 = tcon[tcp_pkg::TF1_BIT];
		return r;
	endfunction

	function automatic row_t row(tcp_pkg::cmd_t c, logic [7:0] a, logic [7:0] d, bit p0,
			bit p1, bit typed, logic [7:0] rd, bit i0, bit i1);
		row_t r;
		r.it.cmd = c;
		r.it.sfr_addr = a;
		r.it.write_data = d;
		r.it.int0_level = p0;
		r.it.int1_level = p1;
		r.typed = typed;
		r.want.read_data = rd;
		r.want.irq0 = i0;
		r.want.irq1 = i1;
		return r;
	endfunction

	function automatic tcp_pkg::item_t random_item();
		tcp_pkg::item_t it;
		int    k;
		k = $urandom_range(0, 99);
		it.int0_level = 1'($urandom_range(0, 1));
		it.int1_level = 1'($urandom_range(0, 1));
		it.write_data = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0)
			it.sfr_addr = 8'($urandom_range(ADDR_LOWEST, ADDR_HIGHEST));
		else
			it.sfr_addr = 8'($urandom_range(tcp_pkg::ADDR_TCON, tcp_pkg::ADDR_TH1));
		if (k < 45)
			it.cmd = tcp_pkg::CMD_TICK;
		else if (k < 65)
			it.cmd = tcp_pkg::CMD_READ;
		else if (k < 88)
			it.cmd = tcp_pkg::CMD_WRITE;
		else if (k < 93)
			it.cmd = tcp_pkg::CMD_ACK0;
		else if (k < 98)
			it.cmd = tcp_pkg::CMD_ACK1;
		else
			it.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		// push counters near the top so overflows happen often
		if (it.cmd == tcp_pkg::CMD_WRITE && it.sfr_addr >= tcp_pkg::ADDR_TL0
				&& it.sfr_addr <= tcp_pkg::ADDR_TH1 && $urandom_range(0, 2) == 0)
			it.write_data = 8'($urandom_range(8'he0, tcp_pkg::COUNT_MAX));
		// most TCON writes start timer 0 with flags clear
		if (it.cmd == tcp_pkg::CMD_WRITE && it.sfr_addr == tcp_pkg::ADDR_TCON
				&& $urandom_range(0, 3) != 0) begin
			it.write_data[tcp_pkg::TF0_BIT] = 1'b0;
			it.write_data[tcp_pkg::TF1_BIT] = 1'b0;
			it.write_data[tcp_pkg::TR0_BIT] = 1'b1;
		end
		return it;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (steady || k < 65)
			return 0;
		else if (k < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input row_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		preset_q.push_back(r);
		item_ch.valid <= 1'b1;
		item_ch.data <= r.it;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	// transfers on both channels, sampled before the edge takes effect
	always @(posedge clk) begin : watch
		row_t             plan;
		tcp_pkg::result_t pred;
		tcp_pkg::result_t got;
		tcp_pkg::result_t want;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			pred = timer_pair_step(item_ch.data);
			plan = preset_q.pop_front();
			reply_q.push_back(plan.typed ? plan.want : pred);
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			replies_seen++;
			got = result_ch.data;
			if (reply_q.size() == 0) begin
				report_mismatch("result with no item pending", int'(got), 0);
			end else begin
				want = reply_q.pop_front();
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", int'(got.read_data),
						int'(want.read_data));
				if (got.irq0 !== want.irq0)
					report_mismatch("irq0", int'(got.irq0), int'(want.irq0));
				if (got.irq1 !== want.irq1)
					report_mismatch("irq1", int'(got.irq1), int'(want.irq1));
			end
		end
	end

	// receiver side
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && replies_seen >= LONG_HOLD_AT) begin
				// long back-pressure so the block fills and stalls its input
				long_hold_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD_LEN) @(posedge clk);
			end else if (steady) begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				result_ch.ready <= 1'b0;
				if ($urandom_range(0, 99) < 85)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else
					repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// sender side
	initial begin
		row_t r;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows = '{
			row(tcp_pkg::CMD_READ, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 1, 8'h00, 0, 0),
			row(tcp_pkg::CMD_READ, tcp_pkg::ADDR_TH1, 8'h00, 1, 1, 1, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TL0, 8'hff, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TH0, 8'hff, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TCON, 8'h10, 0, 0, 1, 8'h00, 0, 0),
			// 13-bit counter wraps on the first tick
			row(tcp_pkg::CMD_TICK, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 1, 8'h00, 1, 0),
			row(tcp_pkg::CMD_READ, tcp_pkg::ADDR_TL0, 8'h00, 0, 0, 1, 8'h00, 1, 0),
			row(tcp_pkg::CMD_ACK0, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 1, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TCON, 8'hff, 0, 0, 1, 8'h00, 1, 1),
			row(tcp_pkg::CMD_ACK1, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 1, 8'h00, 1, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 1, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, ADDR_LOWEST, 8'hff, 0, 0, 1, 8'h00, 0, 0),
			row(tcp_pkg::CMD_READ, ADDR_HIGHEST, 8'hff, 1, 1, 1, 8'h00, 0, 0),
			row(CMD_SPARE_LAST, tcp_pkg::ADDR_TCON, 8'hff, 1, 1, 1, 8'h00, 0, 0),
			row(CMD_SPARE_FIRST, ADDR_HIGHEST, 8'h00, 0, 0, 1, 8'h00, 0, 0),
			// split timer 0 with TH0 about to wrap
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TH0, 8'hff, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TMOD, 8'h33, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TCON, 8'h50, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_TICK, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_READ, tcp_pkg::ADDR_TH0, 8'h00, 0, 0, 0, 8'h00, 0, 0),
			// gated timers, pins low then high
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TMOD, 8'h88, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_TICK, tcp_pkg::ADDR_TCON, 8'h00, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_TICK, tcp_pkg::ADDR_TCON, 8'h00, 1, 1, 0, 8'h00, 0, 0),
			// auto-reload on timer 1
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TMOD, 8'h22, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TL1, 8'hff, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_WRITE, tcp_pkg::ADDR_TH1, 8'h80, 0, 0, 0, 8'h00, 0, 0),
			row(tcp_pkg::CMD_TICK, tcp_pkg::ADDR_TCON, 8'h00, 1, 1, 0, 8'h00, 0, 0)
		};
		foreach (dir_rows[i])
			send_item(dir_rows[i]);

		r.typed = 1'b0;
		r.want = '0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == QUIET_AT) begin
				// sender goes quiet until every reply is back
				item_ch.valid <= 1'b0;
				wait (preset_q.size() == 0 && reply_q.size() == 0);
				@(posedge clk);
			end
			steady = (i >= STEADY_FROM && i < STEADY_TO);
			r.it = random_item();
			send_item(r);
		end
		steady = 1'b0;
		item_ch.valid <= 1'b0;

		wait (preset_q.size() == 0 && reply_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (reply_q.size() != 0)
			report_mismatch("results never delivered", reply_q.size(), 0);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/tcp_pkg.sv
hw/rtl/tcp_item_if.sv
hw/rtl/tcp_result_if.sv
hw/rtl/tcp_count.sv
hw/rtl/timer_counter_pair_8051_unit.sv
hw/rtl/tcp_checker.sv
tb/tb.sv
